FILE: rtl/saa_pkg.sv
// ----------------------------------------------------------------------------
// saa_pkg: shared types and constants of the ascending sorter
// Word width, default capacity, controller states and the cell control word.
// ----------------------------------------------------------------------------
package saa_pkg;

  localparam int DATA_W   = 32;
  localparam int CAPACITY = 16;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: rtl/saa_in_if.sv
// ----------------------------------------------------------------------------
// saa_in_if: input channel of the sorter
// Valid/ready channel carrying one sample word and its batch end flag.
// ----------------------------------------------------------------------------
interface saa_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [saa_pkg::DATA_W-1:0] sample_value;
  logic                              batch_end;

  modport source (output valid, output sample_value, output batch_end, input ready);
  modport sink   (input valid, input sample_value, input batch_end, output ready);
endinterface

FILE: rtl/saa_out_if.sv
// ----------------------------------------------------------------------------
// saa_out_if: result channel of the sorter
// Valid/ready channel carrying one sorted word with end and overflow flags.
// ----------------------------------------------------------------------------
interface saa_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [saa_pkg::DATA_W-1:0] sorted_value;
  logic                              run_end;
  logic                              overflow;

  modport source (output valid, output sorted_value, output run_end, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input run_end, input overflow,
                  output ready);
endinterface

FILE: rtl/saa_cell.sv
// ----------------------------------------------------------------------------
// saa_cell: one slot of the insertion chain
// Holds one word. On insert it takes the broadcast word or its left neighbor's
// word to keep the row ascending; on shift it takes its right neighbor's word.
// ----------------------------------------------------------------------------
module saa_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  saa_pkg::cell_ctrl_t               ctrl,
  input  logic signed [saa_pkg::DATA_W-1:0] new_value,
  input  logic signed [saa_pkg::DATA_W-1:0] left_value,
  input  logic                              left_valid,
  input  logic                              left_take,
  input  logic signed [saa_pkg::DATA_W-1:0] right_value,
  input  logic                              right_valid,
  output logic signed [saa_pkg::DATA_W-1:0] value,
  output logic                              valid,
  output logic                              take
);

  logic signed [saa_pkg::DATA_W-1:0] fill_value;

  // strictly greater: equal words stay ahead of the new one
  assign take       = valid && (new_value < value);
  assign fill_value = left_take ? left_value : new_value;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= right_value;
    end else if (ctrl.insert && (take || (!valid && left_valid))) begin
      value <= fill_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right_valid;
    end else if (ctrl.insert && !valid && left_valid) begin
      valid <= 1'b1;
    end
  end

endmodule

FILE: rtl/sort_array_ascending_core.sv
// ----------------------------------------------------------------------------
// sort_array_ascending_core: batch sorter built as a systolic insertion chain
// ----------------------------------------------------------------------------
// Words arrive on samples, one signed value per word; batch_end marks the
// last word of a batch. Each accepted word is inserted into a row of CAPACITY
// cells as it arrives; samples is ready throughout loading. Equal values keep
// their arrival order. Words beyond CAPACITY are dropped and the batch's
// results carry overflow.
// After the batch_end word, the row drains on results starting the next
// cycle, lowest value first, one word per cycle while the receiver is ready;
// run_end flags the last one. samples is not ready while the row drains; it
// reopens in the cycle after the run_end word is taken. A stalled receiver
// simply holds the head cell. Reset (rst, synchronous) empties the row and
// clears the overflow mark.
// ----------------------------------------------------------------------------
module sort_array_ascending_core #(
  parameter int CAPACITY = saa_pkg::CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  saa_in_if.sink    samples,
  saa_out_if.source results
);

  saa_pkg::state_t   state, state_next;
  saa_pkg::cell_ctrl_t ctrl;
  logic              dropped;
  logic              full;
  logic              load_fire;
  logic              drain_fire;

  logic signed [saa_pkg::DATA_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]               cell_valid;
  logic [CAPACITY-1:0]               cell_take;

  assign full       = cell_valid[CAPACITY-1];
  assign load_fire  = samples.valid && samples.ready;
  assign drain_fire = results.valid && results.ready;

  always_comb begin
    state_next = state;
    case (state)
      saa_pkg::ST_LOAD: begin
        if (load_fire && samples.batch_end) state_next = saa_pkg::ST_DRAIN;
      end
      saa_pkg::ST_DRAIN: begin
        if (drain_fire && results.run_end) state_next = saa_pkg::ST_LOAD;
      end
      default: state_next = saa_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    samples.ready = 1'b0;
    results.valid = 1'b0;
    ctrl.insert   = 1'b0;
    ctrl.shift    = 1'b0;
    case (state)
      saa_pkg::ST_LOAD: begin
        samples.ready = 1'b1;
        ctrl.insert   = load_fire && !full;
      end
      saa_pkg::ST_DRAIN: begin
        results.valid = 1'b1;
        ctrl.shift    = drain_fire;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= saa_pkg::ST_LOAD;
      dropped <= 1'b0;
    end else begin
      state <= state_next;
      if (load_fire && full) begin
        dropped <= 1'b1;
      end else if (drain_fire && results.run_end) begin
        dropped <= 1'b0;
      end
    end
  end

  assign results.sorted_value = cell_value[0];
  assign results.run_end      = !cell_valid[1];
  assign results.overflow     = dropped;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [saa_pkg::DATA_W-1:0] left_value;
    logic                              left_valid;
    logic                              left_take;
    logic signed [saa_pkg::DATA_W-1:0] right_value;
    logic                              right_valid;

    if (i == 0) begin : g_head
      assign left_value = samples.sample_value;
      assign left_valid = 1'b1;
      assign left_take  = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_take  = cell_take[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[i];
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_valid = cell_valid[i+1];
    end

    saa_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_value   (samples.sample_value),
      .left_value  (left_value),
      .left_valid  (left_valid),
      .left_take   (left_take),
      .right_value (right_value),
      .right_valid (right_valid),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .take        (cell_take[i])
    );
  end

endmodule
